// File: src/hrp_pkg.sv
// shared types, codes and helpers of the request head parser
package hrp_pkg;

    // byte codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    // parse phases, equal to the field kinds they emit
    localparam logic [2:0] PH_METHOD  = 3'd0;
    localparam logic [2:0] PH_URL     = 3'd1;
    localparam logic [2:0] PH_VERSION = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_VALUE   = 3'd4;

    localparam logic [1:0] VERDICT_OK        = 2'd0;
    localparam logic [1:0] VERDICT_BAD       = 2'd1;
    localparam logic [1:0] VERDICT_MALFORMED = 2'd2;

    localparam logic [1:0] METHOD_LEN = 2'd3;

    // results per request byte and run queue size
    localparam int RUN_MAX = 4;
    localparam int RUN_CW  = $clog2(RUN_MAX + 1);
    localparam int RUN_IW  = $clog2(RUN_MAX);
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [2:0] phase;
        logic       cr_pending;
        logic       colon_pending;
        logic [1:0] pct_count;
        logic [7:0] pct_first;
        logic [1:0] match_pos;
        logic       is_get;
        logic       prev_dot;
        logic       saw_dotdot;
        logic       line_len;
    } hrp_state_t;

    localparam hrp_state_t ST_RESET = '{
        phase:         PH_METHOD,
        cr_pending:    1'b0,
        colon_pending: 1'b0,
        pct_count:     2'd0,
        pct_first:     8'd0,
        match_pos:     2'd0,
        is_get:        1'b1,
        prev_dot:      1'b0,
        saw_dotdot:    1'b0,
        line_len:      1'b0
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] field_kind;
        logic       field_end;
        logic [3:0] header_slot;
        logic       header_kept;
        logic       key_cancel;
        logic       request_done;
        logic [1:0] verdict;
    } hrp_res_t;

    typedef struct packed {
        hrp_res_t [RUN_MAX-1:0] res;
        logic [RUN_CW-1:0]      cnt;
    } hrp_run_t;

    // msb flags a hex digit, low nibble is its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // lower-case letters of the accepted method
    function automatic logic [7:0] method_letter(input logic [1:0] pos);
        logic [7:0] r;
        unique case (pos)
            2'd0: r = 8'h67;
            2'd1: r = 8'h65;
            2'd2: r = 8'h74;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// File: src/hrp_front.sv
// front end: takes request bytes, tracks parse state, builds the result run of each byte
module hrp_front
    import hrp_pkg::*;
#(
    parameter int MAX_HEADERS = 12
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] in_byte,
    output logic       push,
    output hrp_run_t   run
);

    localparam int CW = $clog2(MAX_HEADERS + 1);
    localparam int EW = CW + 4;
    localparam logic [CW-1:0] MAXH = CW'(MAX_HEADERS);

    typedef struct packed {
        hrp_state_t  s;
        logic [CW-1:0] hc;
        hrp_run_t    q;
    } work_t;

    hrp_state_t    st_reg, st_next;
    logic [CW-1:0] hc_reg, hc_next;
    work_t         w;
    logic          eol_taken;

    function automatic work_t put(input work_t wi, input logic [7:0] byt, input logic vld,
                                  input logic [2:0] kind, input logic fend,
                                  input logic cancel, input logic done,
                                  input logic [1:0] verdict);
        work_t    wo;
        hrp_res_t r;
        logic     kept;
        logic [EW-1:0] ext;
        wo   = wi;
        ext  = EW'(wi.hc);
        kept = (kind == PH_KEY || kind == PH_VALUE) && !done && (wi.hc < MAXH);
        r.out_byte     = vld ? byt : 8'd0;
        r.byte_valid   = vld;
        r.field_kind   = done ? PH_METHOD : kind;
        r.field_end    = fend;
        r.header_slot  = kept ? ext[3:0] : 4'd0;
        r.header_kept  = kept;
        r.key_cancel   = cancel;
        r.request_done = done;
        r.verdict      = done ? verdict : VERDICT_OK;
        if (wi.q.cnt < RUN_CW'(RUN_MAX)) begin
            wo.q.res[wi.q.cnt[RUN_IW-1:0]] = r;
            wo.q.cnt = wi.q.cnt + 1'b1;
        end
        return wo;
    endfunction

    function automatic work_t content(input work_t wi, input logic [7:0] b);
        work_t      wo;
        logic [7:0] lc;
        wo = wi;
        lc = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_GAP : b;
        if (wi.s.phase == PH_METHOD) begin
            if (wi.s.match_pos < METHOD_LEN && lc == method_letter(wi.s.match_pos)) begin
                wo.s.match_pos = wi.s.match_pos + 1'b1;
            end else begin
                wo.s.is_get = 1'b0;
            end
        end else if (wi.s.phase == PH_URL) begin
            if (b == CH_DOT) begin
                if (wi.s.prev_dot) wo.s.saw_dotdot = 1'b1;
                wo.s.prev_dot = 1'b1;
            end else begin
                wo.s.prev_dot = 1'b0;
            end
        end else if (wi.s.phase == PH_KEY) begin
            wo.s.line_len = 1'b1;
        end
        return put(wo, b, 1'b1, wi.s.phase, 1'b0, 1'b0, 1'b0, VERDICT_OK);
    endfunction

    // held escape bytes go out raw
    function automatic work_t flush_pct(input work_t wi);
        work_t wo;
        wo = wi;
        if (wi.s.pct_count >= 2'd1) wo = content(wo, CH_PCT);
        if (wi.s.pct_count >= 2'd2) wo = content(wo, wi.s.pct_first);
        wo.s.pct_count = 2'd0;
        return wo;
    endfunction

    function automatic work_t url_byte(input work_t wi, input logic [7:0] b);
        work_t      wo;
        logic [4:0] hb;
        logic [4:0] hf;
        wo = wi;
        hb = hex_digit(b);
        hf = hex_digit(wi.s.pct_first);
        if (wi.s.pct_count == 2'd2 && hb[4]) begin
            wo.s.pct_count = 2'd0;
            wo = content(wo, {hf[3:0], hb[3:0]});
        end else if (wi.s.pct_count == 2'd1 && hb[4]) begin
            wo.s.pct_first = b;
            wo.s.pct_count = 2'd2;
        end else begin
            wo = flush_pct(wo);
            if (b == CH_PCT) wo.s.pct_count = 2'd1;
            else wo = content(wo, b);
        end
        return wo;
    endfunction

    function automatic work_t finish(input work_t wi, input logic [1:0] verdict);
        work_t wo;
        wo      = put(wi, 8'd0, 1'b0, PH_METHOD, 1'b0, 1'b0, 1'b1, verdict);
        wo.s    = ST_RESET;
        wo.hc   = '0;
        return wo;
    endfunction

    function automatic work_t end_of_line(input work_t wi);
        work_t wo;
        logic  good;
        wo   = wi;
        good = wi.s.is_get && (wi.s.match_pos == METHOD_LEN) && !wi.s.saw_dotdot;
        unique case (wi.s.phase)
            PH_VERSION: begin
                wo = put(wo, 8'd0, 1'b0, PH_VERSION, 1'b1, 1'b0, 1'b0, VERDICT_OK);
                wo.s.phase         = PH_KEY;
                wo.s.line_len      = 1'b0;
                wo.s.colon_pending = 1'b0;
            end
            PH_KEY: begin
                // line without colon-space ends the head
                if (wi.s.line_len) begin
                    wo = put(wo, 8'd0, 1'b0, PH_KEY, 1'b0, 1'b1, 1'b0, VERDICT_OK);
                end
                wo = finish(wo, good ? VERDICT_OK : VERDICT_BAD);
            end
            PH_VALUE: begin
                wo = put(wo, 8'd0, 1'b0, PH_VALUE, 1'b1, 1'b0, 1'b0, VERDICT_OK);
                if (wi.hc < MAXH) wo.hc = wi.hc + 1'b1;
                wo.s.phase         = PH_KEY;
                wo.s.line_len      = 1'b0;
                wo.s.colon_pending = 1'b0;
            end
            default: begin
                wo = finish(wo, VERDICT_MALFORMED);
            end
        endcase
        return wo;
    endfunction

    function automatic work_t ordinary(input work_t wi, input logic [7:0] b);
        work_t wo;
        wo = wi;
        unique case (wi.s.phase)
            PH_METHOD: begin
                if (b == CH_SP) begin
                    wo = put(wo, 8'd0, 1'b0, PH_METHOD, 1'b1, 1'b0, 1'b0, VERDICT_OK);
                    wo.s.phase = PH_URL;
                end else begin
                    wo = content(wo, b);
                end
            end
            PH_URL: begin
                if (b == CH_SP) begin
                    wo = flush_pct(wo);
                    wo = put(wo, 8'd0, 1'b0, PH_URL, 1'b1, 1'b0, 1'b0, VERDICT_OK);
                    wo.s.phase = PH_VERSION;
                end else begin
                    wo = url_byte(wo, b);
                end
            end
            PH_KEY: begin
                if (wi.s.colon_pending && b == CH_SP) begin
                    wo.s.colon_pending = 1'b0;
                    wo = put(wo, 8'd0, 1'b0, PH_KEY, 1'b1, 1'b0, 1'b0, VERDICT_OK);
                    wo.s.phase = PH_VALUE;
                end else begin
                    // colon not followed by space is a plain key byte
                    if (wi.s.colon_pending) begin
                        wo.s.colon_pending = 1'b0;
                        wo = content(wo, CH_COLON);
                    end
                    if (b == CH_COLON) wo.s.colon_pending = 1'b1;
                    else wo = content(wo, b);
                end
            end
            default: begin
                wo = content(wo, b);
            end
        endcase
        return wo;
    endfunction

    always_comb begin
        w         = '0;
        w.s       = st_reg;
        w.hc      = hc_reg;
        eol_taken = 1'b0;
        if (w.s.cr_pending) begin
            w.s.cr_pending = 1'b0;
            if (in_byte == CH_LF) begin
                w         = end_of_line(w);
                eol_taken = 1'b1;
            end else begin
                // lone cr is content
                w = ordinary(w, CH_CR);
            end
        end
        if (!eol_taken) begin
            if (in_byte == CH_CR) begin
                if (w.s.phase == PH_URL) w = flush_pct(w);
                if (w.s.phase == PH_KEY && w.s.colon_pending) begin
                    w.s.colon_pending = 1'b0;
                    w = content(w, CH_COLON);
                end
                w.s.cr_pending = 1'b1;
            end else begin
                w = ordinary(w, in_byte);
            end
        end
        st_next = w.s;
        hc_next = w.hc;
    end

    assign run  = w.q;
    assign push = accept && (w.q.cnt != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_RESET;
            hc_reg <= '0;
        end else if (accept) begin
            st_reg <= st_next;
            hc_reg <= hc_next;
        end
    end

endmodule

// File: src/hrp_queue.sv
// short queue of result runs between front and back
module hrp_queue
    import hrp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  hrp_run_t push_run,
    input  logic     pop,
    output hrp_run_t head_run,
    output logic     empty,
    output logic     full
);

    hrp_run_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CW-1:0]   count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == Q_CW'(Q_DEPTH));
    assign head_run = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/hrp_back.sv
// back end: walks each queued run and hands its results out one per cycle while out_ready is high
module hrp_back
    import hrp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  hrp_run_t head_run,
    input  logic     empty,
    output logic     pop,
    output logic     out_valid,
    input  logic     out_ready,
    output hrp_res_t out_res,
    output logic     out_last
);

    logic [RUN_IW-1:0] idx_reg, idx_next;
    logic              valid_reg, valid_next;
    hrp_res_t          res_reg;
    logic              last_reg;
    logic              load;
    logic              at_last;

    assign load    = !empty && (!valid_reg || out_ready);
    assign at_last = (RUN_CW'(idx_reg) + 1'b1) == head_run.cnt;
    assign pop     = load && at_last;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = at_last ? '0 : idx_reg + 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg  <= head_run.res[idx_reg];
            last_reg <= at_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule

// File: src/http_request_head_parser_core.sv
// top level of the http request head parser: front, run queue and back
//
//  channel | dir | tdata                                   | tuser / tlast
//  s_      | in  | [7:0] in_byte                           | none
//  m_      | out | [7:0] out_byte [11:8] header_slot       | tuser [0] byte_valid [3:1] field_kind
//          |     | [13:12] verdict [15:14] zero            | [4] field_end [5] header_kept
//          |     |                                         | [6] key_cancel [7] request_done
//          |     |                                         | tlast: last result of the byte
//
// one request byte per cycle while the run queue is not full; a byte is parsed in the cycle it
// is taken and its results (zero to four) are queued as one run, which reaches m_ through the
// queue entry and the back end's output register; the back end sends one result per cycle while
// m_tready is high; a four-run queue lets the input keep flowing while the output side stalls
// s_tready drops only when the run queue is full
// synchronous active-low reset returns the parser to the method field of a new request
module http_request_head_parser_core
    import hrp_pkg::*;
#(
    parameter int MAX_HEADERS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] header_slot, [13:12] verdict
    output logic [7:0]  m_tuser,   // byte_valid, field_kind[2:0], field_end, header_kept,
                                   // key_cancel, request_done
    output logic        m_tlast
);

    logic     accept;
    logic     q_push;
    hrp_run_t q_in;
    logic     q_pop;
    hrp_run_t q_head;
    logic     q_empty;
    logic     q_full;
    hrp_res_t m_res;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    hrp_front #(
        .MAX_HEADERS(MAX_HEADERS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .in_byte (s_tdata),
        .push    (q_push),
        .run     (q_in)
    );

    hrp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_run (q_in),
        .pop      (q_pop),
        .head_run (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    hrp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_run  (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (m_res),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, m_res.verdict, m_res.header_slot, m_res.out_byte};
    assign m_tuser = {m_res.request_done, m_res.key_cancel, m_res.header_kept,
                      m_res.field_end, m_res.field_kind, m_res.byte_valid};

    // a run is never written over
    assert property (@(posedge aclk) disable iff (!aresetn) !(q_push && q_full))
        else $error("run queue overflow");

    // rest of a run is already queued, so results of one byte follow without a gap
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("gap inside a result run");

    // kept headers come only with key or value fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_res.header_kept) |->
        (m_res.field_kind == PH_KEY || m_res.field_kind == PH_VALUE))
        else $error("header slot on a non-header result");

    // an idle block always takes input
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_empty && !m_tvalid) |-> s_tready)
        else $error("idle block refuses input");

endmodule

// File: tb/tb.sv
// testbench for http_request_head_parser_core: byte stream in, tagged results checked in order
`timescale 1ns / 1ps

module tb;
    import hrp_pkg::*;

    localparam int SLOT_LIMIT  = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int BYTE_TARGET = 360;
    localparam int DRAIN_WAIT  = 16;
    localparam logic [23:0] METHOD_WORD = "get";
    localparam logic [31:0] METHOD_MIX  = "getx";

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [2:0] field_kind;
        logic       field_end;
        logic [3:0] header_slot;
        logic       header_kept;
        logic       key_cancel;
        logic       request_done;
        logic [1:0] verdict;
        logic       last_of_run;
    } tag_result_t;

    class tag_scoreboard;
        logic [2:0]  phase;
        bit          cr_wait;
        bit          colon_wait;
        int          pct_held;
        logic [7:0]  pct_first;
        int          get_pos;
        bit          is_get;
        bit          prev_dot;
        bit          dotdot;
        bit          line_nonempty;
        int          hdr_count;
        int          max_headers;
        int          errors;
        tag_result_t step_tags[$];
        tag_result_t pending_tags[$];

        function new(int slots);
            max_headers = slots;
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_METHOD;
            cr_wait = 0;
            colon_wait = 0;
            pct_held = 0;
            pct_first = 8'd0;
            get_pos = 0;
            is_get = 1;
            prev_dot = 0;
            dotdot = 0;
            line_nonempty = 0;
            hdr_count = 0;
        endfunction

        function int hex_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return -1;
        endfunction

        function void emit(logic [7:0] b, bit valid, logic [2:0] kind, bit closes, bit cancel,
                           bit done, logic [1:0] vd);
            tag_result_t r;
            bit hdr;
            hdr = (kind == PH_KEY || kind == PH_VALUE) && !done;
            if (step_tags.size() >= RUN_MAX) return;
            r = '0;
            r.out_byte = valid ? b : 8'd0;
            r.byte_valid = valid;
            r.field_kind = done ? PH_METHOD : kind;
            r.field_end = closes;
            r.header_kept = hdr && hdr_count < max_headers;
            r.header_slot = r.header_kept ? 4'(hdr_count) : 4'd0;
            r.key_cancel = cancel;
            r.request_done = done;
            r.verdict = done ? vd : VERDICT_OK;
            step_tags.push_back(r);
        endfunction

        function void content(logic [7:0] b);
            logic [7:0] lc;
            if (phase == PH_METHOD) begin
                lc = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_GAP : b;
                if (get_pos < 3 && lc == METHOD_WORD[23 - 8 * get_pos -: 8]) begin
                    get_pos++;
                end else begin
                    is_get = 0;
                end
            end else if (phase == PH_URL) begin
                if (b == CH_DOT) begin
                    if (prev_dot) dotdot = 1;
                    prev_dot = 1;
                end else begin
                    prev_dot = 0;
                end
            end else if (phase == PH_KEY) begin
                line_nonempty = 1;
            end
            emit(b, 1, phase, 0, 0, 0, VERDICT_OK);
        endfunction

        function void flush_pct();
            if (pct_held >= 1) content(CH_PCT);
            if (pct_held >= 2) content(pct_first);
            pct_held = 0;
        endfunction

        function void url_byte(logic [7:0] b);
            int lo;
            lo = hex_of(b);
            if (pct_held == 2 && lo >= 0) begin
                pct_held = 0;
                content(8'(hex_of(pct_first) * 16 + lo));
                return;
            end
            if (pct_held == 1 && lo >= 0) begin
                pct_first = b;
                pct_held = 2;
                return;
            end
            flush_pct();
            if (b == CH_PCT) pct_held = 1;
            else content(b);
        endfunction

        function void close(logic [1:0] vd);
            emit(8'd0, 0, PH_METHOD, 0, 0, 1, vd);
            clear();
        endfunction

        function void line_end();
            case (phase)
                PH_VERSION: begin
                    emit(8'd0, 0, PH_VERSION, 1, 0, 0, VERDICT_OK);
                    phase = PH_KEY;
                    line_nonempty = 0;
                    colon_wait = 0;
                end
                PH_KEY: begin
                    // a line without colon-space ends the head
                    if (line_nonempty) emit(8'd0, 0, PH_KEY, 0, 1, 0, VERDICT_OK);
                    close((is_get && get_pos == 3 && !dotdot) ? VERDICT_OK : VERDICT_BAD);
                end
                PH_VALUE: begin
                    emit(8'd0, 0, PH_VALUE, 1, 0, 0, VERDICT_OK);
                    if (hdr_count < max_headers) hdr_count++;
                    phase = PH_KEY;
                    line_nonempty = 0;
                    colon_wait = 0;
                end
                default: close(VERDICT_MALFORMED);
            endcase
        endfunction

        function void plain(logic [7:0] b);
            case (phase)
                PH_METHOD: begin
                    if (b == CH_SP) begin
                        emit(8'd0, 0, PH_METHOD, 1, 0, 0, VERDICT_OK);
                        phase = PH_URL;
                    end else begin
                        content(b);
                    end
                end
                PH_URL: begin
                    if (b == CH_SP) begin
                        flush_pct();
                        emit(8'd0, 0, PH_URL, 1, 0, 0, VERDICT_OK);
                        phase = PH_VERSION;
                    end else begin
                        url_byte(b);
                    end
                end
                PH_KEY: begin
                    if (colon_wait) begin
                        colon_wait = 0;
                        if (b == CH_SP) begin
                            emit(8'd0, 0, PH_KEY, 1, 0, 0, VERDICT_OK);
                            phase = PH_VALUE;
                            return;
                        end
                        content(CH_COLON);
                    end
                    if (b == CH_COLON) colon_wait = 1;
                    else content(b);
                end
                default: content(b);
            endcase
        endfunction

        // predicts the results of one accepted request byte
        function void take_byte(logic [7:0] b);
            tag_result_t r;
            bit eol;
            step_tags.delete();
            eol = 0;
            if (cr_wait) begin
                cr_wait = 0;
                if (b == CH_LF) begin
                    line_end();
                    eol = 1;
                end else begin
                    plain(CH_CR);
                end
            end
            if (!eol) begin
                if (b == CH_CR) begin
                    if (phase == PH_URL) flush_pct();
                    if (phase == PH_KEY && colon_wait) begin
                        colon_wait = 0;
                        content(CH_COLON);
                    end
                    cr_wait = 1;
                end else begin
                    plain(b);
                end
            end
            if (step_tags.size() > 0) begin
                r = step_tags.pop_back();
                r.last_of_run = 1;
                step_tags.push_back(r);
            end
            foreach (step_tags[i]) pending_tags.push_back(step_tags[i]);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [15:0] tdata, logic [7:0] tuser, logic tlast);
            tag_result_t want;
            if (pending_tags.size() == 0) begin
                $error("result with nothing expected: tdata %h tuser %h tlast %b",
                       tdata, tuser, tlast);
                errors++;
                return;
            end
            want = pending_tags.pop_front();
            check_field("out_byte", want.out_byte, tdata[7:0]);
            check_field("header_slot", want.header_slot, tdata[11:8]);
            check_field("verdict", want.verdict, tdata[13:12]);
            check_field("byte_valid", want.byte_valid, tuser[0]);
            check_field("field_kind", want.field_kind, tuser[3:1]);
            check_field("field_end", want.field_end, tuser[4]);
            check_field("header_kept", want.header_kept, tuser[5]);
            check_field("key_cancel", want.key_cancel, tuser[6]);
            check_field("request_done", want.request_done, tuser[7]);
            check_field("last_of_run", want.last_of_run, tlast);
        endfunction

        function int tags_waiting();
            return pending_tags.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [7:0]  m_tuser;
    logic        m_tlast;

    tag_scoreboard sb = new(SLOT_LIMIT);
    logic [7:0]    req_bytes[$];
    int            bytes_sent = 0;
    int            quiet = 0;
    bit            calm = 0;

    http_request_head_parser_core #(.MAX_HEADERS(SLOT_LIMIT)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 10);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= STALL_LIMIT) begin
                $display("http_request_head_parser_core: mismatch");
                $finish;
            end
        end
    end

    function automatic void put_text(string s);
        foreach (s[i]) req_bytes.push_back(s[i]);
    endfunction

    function automatic void crlf();
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endfunction

    function automatic void push_any_case(logic [7:0] c);
        req_bytes.push_back($urandom_range(1) ? c - CASE_GAP : c);
    endfunction

    function automatic logic [7:0] text_char();
        case ($urandom_range(9))
            0: return CH_COLON;
            1: return CH_SP;
            2: return 8'($urandom_range(255));
            default: return 8'($urandom_range("a", "z"));
        endcase
    endfunction

    function automatic logic [7:0] url_char();
        int v;
        v = $urandom_range(21);
        case ($urandom_range(11))
            0, 1: return CH_DOT;
            2: return CH_PCT;
            3, 4: return (v < 10) ? 8'("0" + v) : (v < 16) ? 8'("a" + v - 10) : 8'("A" + v - 16);
            5: return "/";
            6: return 8'($urandom_range(255));
            default: return 8'($urandom_range("a", "z"));
        endcase
    endfunction

    // mostly well-formed heads with random content, some noise and cut lines
    function automatic void build_request();
        int  n_hdr;
        bit  crowd;
        req_bytes.delete();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 12)) begin
                case ($urandom_range(5))
                    0: req_bytes.push_back(CH_CR);
                    1: req_bytes.push_back(CH_LF);
                    2: req_bytes.push_back(CH_PCT);
                    default: req_bytes.push_back(text_char());
                endcase
            end
            return;
        end
        if ($urandom_range(9) < 7) begin
            push_any_case("g");
            push_any_case("e");
            push_any_case("t");
        end else begin
            repeat ($urandom_range(1, 4)) push_any_case(METHOD_MIX[8 * $urandom_range(3) +: 8]);
        end
        req_bytes.push_back(CH_SP);
        repeat ($urandom_range(1, 8)) req_bytes.push_back(url_char());
        if ($urandom_range(9) == 0) begin
            crlf();
            return;
        end
        req_bytes.push_back(CH_SP);
        repeat ($urandom_range(1, 3)) req_bytes.push_back(text_char());
        crlf();
        crowd = ($urandom_range(7) == 0);
        n_hdr = crowd ? $urandom_range(12, 14) : $urandom_range(0, 3);
        repeat (n_hdr) begin
            repeat (crowd ? $urandom_range(1) : $urandom_range(4)) req_bytes.push_back(text_char());
            req_bytes.push_back(CH_COLON);
            req_bytes.push_back(CH_SP);
            repeat (crowd ? $urandom_range(1) : $urandom_range(4)) begin
                req_bytes.push_back($urandom_range(1) ? text_char() : 8'($urandom_range(255)));
            end
            crlf();
        end
        if ($urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 3)) req_bytes.push_back(text_char());
        end
        crlf();
    endfunction

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(99) < 10) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_request();
        foreach (req_bytes[i]) send_byte(req_bytes[i]);
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty request line, then a head with a short escape, a decoded zero, an
        // encoded dot, a colon without space, a lone cr and a cancelled last line
        req_bytes.delete();
        crlf();
        put_text("gET %4%00%2e/ ");
        req_bytes.push_back(8'hFF);
        crlf();
        put_text("k:");
        req_bytes.push_back(8'h00);
        req_bytes.push_back(CH_CR);
        put_text("x: ");
        crlf();
        put_text("q");
        crlf();
        send_request();

        while (bytes_sent < BYTE_TARGET) begin
            calm = (bytes_sent >= 150 && bytes_sent < 230);
            build_request();
            send_request();
        end
        s_tvalid <= 1'b0;
        calm = 0;

        while (sb.tags_waiting() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("http_request_head_parser_core: match");
        end else begin
            $display("http_request_head_parser_core: mismatch");
        end
        $finish;
    end

endmodule

// File: http_request_head_parser_core.f
src/hrp_pkg.sv
src/hrp_front.sv
src/hrp_queue.sv
src/hrp_back.sv
src/http_request_head_parser_core.sv
tb/tb.sv
